// ===== rtl/core/ucd_pkg.sv =====
package ucd_pkg;

	// item codes carried in s_tuser
	localparam logic OP_SYNC  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [31:0] DAYS_SHIFT = 32'd719468;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;

	// divisors handled by the shared constant divider
	localparam logic [17:0] D_1000   = 18'd1000;
	localparam logic [17:0] D_60     = 18'd60;
	localparam logic [17:0] D_24     = 18'd24;
	localparam logic [17:0] D_146097 = 18'd146097;
	localparam logic [17:0] D_1460   = 18'd1460;
	localparam logic [17:0] D_36524  = 18'd36524;
	localparam logic [17:0] D_146096 = 18'd146096;
	localparam logic [17:0] D_365    = 18'd365;
	localparam logic [17:0] D_100    = 18'd100;
	localparam logic [17:0] D_153    = 18'd153;
	localparam logic [17:0] D_5      = 18'd5;

	// floor(2^32 / d): quotient estimate is exact or one short
	localparam logic [31:0] R_1000   = 32'(64'h1_0000_0000 / 64'(D_1000));
	localparam logic [31:0] R_60     = 32'(64'h1_0000_0000 / 64'(D_60));
	localparam logic [31:0] R_24     = 32'(64'h1_0000_0000 / 64'(D_24));
	localparam logic [31:0] R_146097 = 32'(64'h1_0000_0000 / 64'(D_146097));
	localparam logic [31:0] R_1460   = 32'(64'h1_0000_0000 / 64'(D_1460));
	localparam logic [31:0] R_36524  = 32'(64'h1_0000_0000 / 64'(D_36524));
	localparam logic [31:0] R_146096 = 32'(64'h1_0000_0000 / 64'(D_146096));
	localparam logic [31:0] R_365    = 32'(64'h1_0000_0000 / 64'(D_365));
	localparam logic [31:0] R_100    = 32'(64'h1_0000_0000 / 64'(D_100));
	localparam logic [31:0] R_153    = 32'(64'h1_0000_0000 / 64'(D_153));
	localparam logic [31:0] R_5      = 32'(64'h1_0000_0000 / 64'(D_5));

	typedef enum logic [3:0] {
		DIV_1000,
		DIV_60,
		DIV_24,
		DIV_146097,
		DIV_1460,
		DIV_36524,
		DIV_146096,
		DIV_365,
		DIV_100,
		DIV_153,
		DIV_5
	} div_sel_t;

	typedef struct packed {
		logic        start;
		div_sel_t    sel;
		logic [31:0] x;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] q;
		logic [17:0] r;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAP,
		ST_SEC,
		ST_MIN,
		ST_HOUR,
		ST_ERA,
		ST_D1460,
		ST_D36524,
		ST_D146096,
		ST_YOE,
		ST_D100,
		ST_MP,
		ST_DD,
		ST_OUT
	} state_t;

	function automatic logic [17:0] div_const(div_sel_t sel);
		logic [17:0] d;
		unique case (sel)
			DIV_1000:   d = D_1000;
			DIV_60:     d = D_60;
			DIV_24:     d = D_24;
			DIV_146097: d = D_146097;
			DIV_1460:   d = D_1460;
			DIV_36524:  d = D_36524;
			DIV_146096: d = D_146096;
			DIV_365:    d = D_365;
			DIV_100:    d = D_100;
			DIV_153:    d = D_153;
			DIV_5:      d = D_5;
			default:    d = D_1000;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] div_recip(div_sel_t sel);
		logic [31:0] m;
		unique case (sel)
			DIV_1000:   m = R_1000;
			DIV_60:     m = R_60;
			DIV_24:     m = R_24;
			DIV_146097: m = R_146097;
			DIV_1460:   m = R_1460;
			DIV_36524:  m = R_36524;
			DIV_146096: m = R_146096;
			DIV_365:    m = R_365;
			DIV_100:    m = R_100;
			DIV_153:    m = R_153;
			DIV_5:      m = R_5;
			default:    m = R_1000;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/ucd_cdiv.sv =====
// shared divide-by-constant unit: reciprocal multiply, back-multiply, one fix-up;
// start registers the product, then the back-multiply, then done (corrected q/r valid while done is high)
module ucd_cdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  ucd_pkg::div_req_t req,
	output ucd_pkg::div_rsp_t rsp
);

	logic        v_s1;
	logic        v_s2;
	logic [63:0] prod_s1;
	logic [31:0] x_s1;
	logic [17:0] d_s1;
	logic [17:0] d_s2;
	logic [31:0] q_s2;
	logic [31:0] r_s2;
	logic [31:0] q0;
	logic [49:0] qd;
	logic        fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	assign q0 = prod_s1[63:32];
	assign qd = 50'(q0) * 50'(d_s1);

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= 64'(req.x) * 64'(ucd_pkg::div_recip(req.sel));
			x_s1    <= req.x;
			d_s1    <= ucd_pkg::div_const(req.sel);
		end
		if (v_s1) begin
			q_s2 <= q0;
			r_s2 <= x_s1 - qd[31:0];
			d_s2 <= d_s1;
		end
	end

	// estimate is at most one short: remainder below twice the divisor
	assign fix      = r_s2 >= 32'(d_s2);
	assign rsp.done = v_s2;
	assign rsp.q    = q_s2 + 32'(fix);
	assign rsp.r    = fix ? 18'(r_s2 - 32'(d_s2)) : r_s2[17:0];

endmodule

// ===== rtl/core/unix_time_to_civil_date_core.sv =====
// A query word gives its result after its divisions: 12 when synced, 3 when
// not synced. A sync word is accepted and gives no result.
// One word at a time: s_tready only while idle, so a query holds off the next
// word until its result is taken; every division runs on the single shared
// constant divider.
// Reset (arst_n, async, active low) clears the sequencer, sync flag and references.
module unix_time_to_civil_date_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] unix_seconds, [63:32] uptime_ms
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [11:0] year, [15:12] month, [20:16] day,
	                              // [25:21] hour, [31:26] minute, [37:32] second,
	                              // [39:38] zero
	output logic        m_tuser   // [0] real_time
);

	ucd_pkg::state_t   state_q;
	ucd_pkg::state_t   state_nx;
	ucd_pkg::div_req_t req;
	ucd_pkg::div_rsp_t rsp;

	logic        pending_q;
	logic        synced_q;
	logic [31:0] eref_q;
	logic [31:0] uref_q;

	// working registers of the date walk
	logic [31:0] t_q;
	logic        real_q;
	logic [2:0]  era_q;
	logic [17:0] doe_q;
	logic [17:0] acc_q;
	logic [8:0]  yoe_q;
	logic [8:0]  doy_q;
	logic [3:0]  mp_q;

	// result word
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;

	logic        s_acc;
	logic        step;

	assign s_acc = s_tvalid && s_tready;

	// any state that drives the divider
	assign step = (state_q != ucd_pkg::ST_IDLE) && (state_q != ucd_pkg::ST_OUT);

	ucd_cdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// next state: each step waits for its division, then moves on
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ucd_pkg::ST_IDLE:
				if (s_acc && s_tuser == ucd_pkg::OP_QUERY) state_nx = ucd_pkg::ST_ELAP;
			ucd_pkg::ST_ELAP:    if (rsp.done) state_nx = ucd_pkg::ST_SEC;
			ucd_pkg::ST_SEC:     if (rsp.done) state_nx = ucd_pkg::ST_MIN;
			ucd_pkg::ST_MIN:
				if (rsp.done) state_nx = real_q ? ucd_pkg::ST_HOUR : ucd_pkg::ST_OUT;
			ucd_pkg::ST_HOUR:    if (rsp.done) state_nx = ucd_pkg::ST_ERA;
			ucd_pkg::ST_ERA:     if (rsp.done) state_nx = ucd_pkg::ST_D1460;
			ucd_pkg::ST_D1460:   if (rsp.done) state_nx = ucd_pkg::ST_D36524;
			ucd_pkg::ST_D36524:  if (rsp.done) state_nx = ucd_pkg::ST_D146096;
			ucd_pkg::ST_D146096: if (rsp.done) state_nx = ucd_pkg::ST_YOE;
			ucd_pkg::ST_YOE:     if (rsp.done) state_nx = ucd_pkg::ST_D100;
			ucd_pkg::ST_D100:    if (rsp.done) state_nx = ucd_pkg::ST_MP;
			ucd_pkg::ST_MP:      if (rsp.done) state_nx = ucd_pkg::ST_DD;
			ucd_pkg::ST_DD:      if (rsp.done) state_nx = ucd_pkg::ST_OUT;
			ucd_pkg::ST_OUT:     if (m_tready) state_nx = ucd_pkg::ST_IDLE;
			default:             state_nx = ucd_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshakes and divider operand selection
	always_comb begin
		s_tready  = state_q == ucd_pkg::ST_IDLE;
		m_tvalid  = state_q == ucd_pkg::ST_OUT;
		req.start = step && !pending_q;
		req.sel   = ucd_pkg::DIV_1000;
		req.x     = t_q;
		unique case (state_q)
			ucd_pkg::ST_ELAP:    req.sel = ucd_pkg::DIV_1000;
			ucd_pkg::ST_SEC,
			ucd_pkg::ST_MIN:     req.sel = ucd_pkg::DIV_60;
			ucd_pkg::ST_HOUR:    req.sel = ucd_pkg::DIV_24;
			ucd_pkg::ST_ERA:     req.sel = ucd_pkg::DIV_146097;
			ucd_pkg::ST_D1460: begin
				req.sel = ucd_pkg::DIV_1460;
				req.x   = 32'(doe_q);
			end
			ucd_pkg::ST_D36524: begin
				req.sel = ucd_pkg::DIV_36524;
				req.x   = 32'(doe_q);
			end
			ucd_pkg::ST_D146096: begin
				req.sel = ucd_pkg::DIV_146096;
				req.x   = 32'(doe_q);
			end
			ucd_pkg::ST_YOE: begin
				req.sel = ucd_pkg::DIV_365;
				req.x   = 32'(acc_q);
			end
			ucd_pkg::ST_D100: begin
				req.sel = ucd_pkg::DIV_100;
				req.x   = 32'(yoe_q);
			end
			ucd_pkg::ST_MP: begin
				// 5*doy + 2
				req.sel = ucd_pkg::DIV_153;
				req.x   = 32'({doy_q, 2'b00}) + 32'(doy_q) + 32'd2;
			end
			ucd_pkg::ST_DD: begin
				// 153*mp + 2
				req.sel = ucd_pkg::DIV_5;
				req.x   = 32'(mp_q) * 32'd153 + 32'd2;
			end
			default: begin
				req.sel = ucd_pkg::DIV_1000;
				req.x   = t_q;
			end
		endcase
	end

	// control state and time reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ucd_pkg::ST_IDLE;
			pending_q <= 1'b0;
			synced_q  <= 1'b0;
			eref_q    <= 32'd0;
			uref_q    <= 32'd0;
		end else begin
			state_q <= state_nx;
			if (req.start) begin
				pending_q <= 1'b1;
			end else if (rsp.done) begin
				pending_q <= 1'b0;
			end
			// sync word: replace the reference, no result
			if (s_acc && s_tuser == ucd_pkg::OP_SYNC) begin
				eref_q   <= s_tdata[31:0];
				uref_q   <= s_tdata[63:32];
				synced_q <= 1'b1;
			end
		end
	end

	// datapath: capture each division as it completes
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == ucd_pkg::OP_QUERY) begin
			// elapsed ms wraps at 32 bits; fallback uses raw uptime
			t_q    <= synced_q ? s_tdata[63:32] - uref_q : s_tdata[63:32];
			real_q <= synced_q;
		end
		if (rsp.done) begin
			case (state_q)
				ucd_pkg::ST_ELAP: t_q <= (real_q ? eref_q : 32'd0) + rsp.q;
				ucd_pkg::ST_SEC: begin
					sec_q <= rsp.r[5:0];
					t_q   <= rsp.q;
				end
				ucd_pkg::ST_MIN: begin
					// fallback date, overwritten later on the synced path
					min_q   <= rsp.r[5:0];
					t_q     <= rsp.q;
					hour_q  <= 5'd0;
					year_q  <= ucd_pkg::EPOCH_YEAR;
					month_q <= 4'd1;
					day_q   <= 5'd1;
				end
				ucd_pkg::ST_HOUR: begin
					hour_q <= rsp.r[4:0];
					t_q    <= rsp.q + ucd_pkg::DAYS_SHIFT;
				end
				ucd_pkg::ST_ERA: begin
					era_q <= rsp.q[2:0];
					doe_q <= rsp.r;
				end
				ucd_pkg::ST_D1460:   acc_q <= doe_q - rsp.q[17:0];
				ucd_pkg::ST_D36524:  acc_q <= acc_q + rsp.q[17:0];
				ucd_pkg::ST_D146096: acc_q <= acc_q - rsp.q[17:0];
				ucd_pkg::ST_YOE:     yoe_q <= rsp.q[8:0];
				ucd_pkg::ST_D100:
					// doy = doe - (365*yoe + yoe/4 - yoe/100)
					doy_q <= 9'(doe_q - (18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2])
					                     - 18'(rsp.q[8:0])));
				ucd_pkg::ST_MP:      mp_q <= rsp.q[3:0];
				ucd_pkg::ST_DD: begin
					day_q   <= 5'(doy_q - rsp.q[8:0] + 9'd1);
					month_q <= (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
					// March-based year: January and February belong to the next
					year_q  <= 12'(yoe_q) + 12'(era_q) * 12'd400 + 12'(mp_q >= 4'd10);
				end
				default: ;
			endcase
		end
	end

	assign m_tdata = {2'b00, sec_q, min_q, hour_q, day_q, month_q, year_q};
	assign m_tuser = real_q;

`ifndef SYNTHESIS
	// never take a word while a result is being offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	// divider only answers a request that was made
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> pending_q)
		else $error("divider done without request");

	// only one division in flight
	a_single_issue: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !pending_q && !rsp.done)
		else $error("divider restarted while busy");

	// fallback result is 1970-01-01, hour 0
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> year_q == ucd_pkg::EPOCH_YEAR && month_q == 4'd1
		&& day_q == 5'd1 && hour_q == 5'd0)
		else $error("bad fallback date");

	// calendar fields stay in range on every result
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> month_q >= 4'd1 && month_q <= 4'd12 && day_q != 5'd0
		&& hour_q <= 5'd23 && min_q <= 6'd59 && sec_q <= 6'd59)
		else $error("result field out of range");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for unix_time_to_civil_date_core.
//
// Input words (s_*) carry a sync or a query; only queries give a result word (m_*).
// A local date predictor keeps its own copy of the time reference and works out
// the civil date of every accepted query; results are checked field by field
// against the oldest pending date.
//
// Stimulus: a short directed table, then random sync/query sequences with
// a little noise. The sender runs in bursts with gaps; the receiver stalls on
// its own pattern and, once, holds off long enough to back the block up.
module tb;

	localparam int N_RANDOM   = 1800;
	localparam int QUIET_MAX  = 4000;  // cycles with no word moving either way
	localparam int TAIL_WAIT  = 60;    // longer than a synced query takes
	localparam int HOLD_SPAN  = 400;   // long receiver hold-off
	localparam int HOLD_AFTER = 150;   // results seen before the hold-off starts

	// result fields, in m_tdata order, plus real_time from m_tuser
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        real_time;
	} civil_t;

	// one directed row; typed rows carry their date, the rest use the predictor
	typedef struct packed {
		logic        op;
		logic [31:0] secs;
		logic [31:0] up_ms;
		logic        typed;
		civil_t      want;
	} stim_t;

	localparam civil_t NO_DATE = '0;
	localparam int N_DIR = 23;

	stim_t dir_tab [N_DIR] = '{
		// not synced yet: 1970-01-01, hour 0, minute/second from uptime
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
		'{ucd_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd2, 6'd47, 1'b0}},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd59999, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd59, 1'b0}},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd60000, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd1, 6'd0, 1'b0}},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd3599999, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd59, 6'd59, 1'b0}},
		'{ucd_pkg::OP_QUERY, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_DATE},
		// synced at the epoch
		'{ucd_pkg::OP_SYNC,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd999, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd1000, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1, 1'b1}},
		// top of the 32-bit range, then the epoch sum wrapping back to 1970
		'{ucd_pkg::OP_SYNC,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 1'b1}},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd1000, 1'b1,
			'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
		'{ucd_pkg::OP_SYNC,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'd999, 1'b1,
			'{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 1'b1}},
		// leap day reached across an uptime wrap
		'{ucd_pkg::OP_SYNC,  32'd951782399, 32'hFFFF_FC18, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_DATE},
		// repeated sync replaces the reference
		'{ucd_pkg::OP_SYNC,  32'h1234_5678, 32'h8000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, NO_DATE},
		'{ucd_pkg::OP_SYNC,  32'h5F5E_0FFF, 32'h0000_0001, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATE},
		'{ucd_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0001_2345, 1'b0, NO_DATE}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;  // [31:0] unix_seconds, [63:32] uptime_ms
	logic        s_tuser  = ucd_pkg::OP_SYNC;  // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;  // year, month, day, hour, minute, second, pad
	logic        m_tuser;  // [0] real_time

	// travel with the word so the monitor knows whether a typed date applies
	logic   word_typed = 1'b0;
	civil_t word_want  = '0;

	// predictor's copy of the time reference
	logic        ref_ok    = 1'b0;
	logic [31:0] ref_epoch = '0;
	logic [31:0] ref_up    = '0;

	civil_t pending_dates [$];
	civil_t got_date, want_date;
	int n_errors  = 0;
	int n_results = 0;
	int n_quiet   = 0;
	int burst_left = 0;

	unix_time_to_civil_date_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Date the block should report for a query at now_ms, from the kept reference.
	function automatic civil_t civil_of(input logic [31:0] now_ms);
		civil_t c;
		logic [31:0] t, z, era, doe, yoe, yr, doy, mp, mm;
		c.real_time = ref_ok;
		if (!ref_ok) begin
			// uptime fallback: day and hour pinned to the epoch
			t = now_ms / 32'd1000;
			c.year   = 12'd1970;
			c.month  = 4'd1;
			c.day    = 5'd1;
			c.hour   = 5'd0;
			c.minute = 6'((t / 32'd60) % 32'd60);
			c.second = 6'(t % 32'd60);
		end else begin
			// elapsed ms wraps as a 32-bit subtraction, the sum wraps too
			t = ref_epoch + (now_ms - ref_up) / 32'd1000;
			c.second = 6'(t % 32'd60);
			t = t / 32'd60;
			c.minute = 6'(t % 32'd60);
			t = t / 32'd60;
			c.hour = 5'(t % 32'd24);
			t = t / 32'd24;
			// days to civil, shifted to a March-based year
			z   = t + ucd_pkg::DAYS_SHIFT;
			era = z / 32'd146097;
			doe = z - era * 32'd146097;
			yoe = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
			yr  = yoe + era * 32'd400;
			doy = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
			mp  = (32'd5 * doy + 32'd2) / 32'd153;
			c.day = 5'(doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1);
			mm  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
			if (mm <= 32'd2)
				yr = yr + 32'd1;
			c.month = 4'(mm);
			c.year  = 12'(yr);
		end
		return c;
	endfunction

	function automatic void cmp_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			n_errors++;
		end
	endfunction

	// Monitor: values seen here are those from just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got_date = '{m_tdata[11:0], m_tdata[15:12], m_tdata[20:16],
					m_tdata[25:21], m_tdata[31:26], m_tdata[37:32], m_tuser};
				if (pending_dates.size() == 0) begin
					$error("result word with no query waiting");
					n_errors++;
				end else begin
					want_date = pending_dates.pop_front();
					cmp_field("year",      want_date.year,      got_date.year);
					cmp_field("month",     want_date.month,     got_date.month);
					cmp_field("day",       want_date.day,       got_date.day);
					cmp_field("hour",      want_date.hour,      got_date.hour);
					cmp_field("minute",    want_date.minute,    got_date.minute);
					cmp_field("second",    want_date.second,    got_date.second);
					cmp_field("real_time", want_date.real_time, got_date.real_time);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ucd_pkg::OP_SYNC) begin
					ref_ok    = 1'b1;
					ref_epoch = s_tdata[31:0];
					ref_up    = s_tdata[63:32];
				end else if (word_typed) begin
					pending_dates.push_back(word_want);
				end else begin
					pending_dates.push_back(civil_of(s_tdata[63:32]));
				end
			end
			// watchdog
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				n_quiet = 0;
			else
				n_quiet++;
			if (n_quiet >= QUIET_MAX) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: a stall pattern that changes every so often, one long hold-off.
	initial begin : rx_pattern
		int mode, span, phase;
		logic held;
		phase = 0;
		held  = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(posedge clk);
				if (!held && n_results >= HOLD_AFTER) begin
					// block fills with one result and must stall its input
					held = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_SPAN) @(posedge clk);
				end
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= ((phase % 8) >= 3);
				endcase
				phase++;
			end
		end
	end

	// Offer one word and wait for it to be taken. Bursts with gaps between.
	task automatic send_word(input logic op, input logic [31:0] secs,
			input logic [31:0] up_ms, input logic typed, input civil_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= {up_ms, secs};
		s_tuser    <= op;
		word_typed <= typed;
		word_want  <= want;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Sync seconds: full range, near either end, or just around midnight.
	function automatic logic [31:0] pick_epoch();
		case ($urandom_range(0, 3))
			0:       return $urandom();
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 200000);
			2:       return $urandom_range(0, 200000);
			default: return $urandom_range(0, 49709) * 32'd86400 + $urandom_range(0, 10) - 5;
		endcase
	endfunction

	// Elapsed ms after a sync: short, medium, anything, or close to a full wrap.
	function automatic logic [31:0] pick_elapsed();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 5000);
			1:       return $urandom_range(0, 100000000);
			2:       return $urandom();
			default: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
		endcase
	endfunction

	initial begin : stimulus
		int n_sent, n_q;
		logic [31:0] sync_up;
		n_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].secs, dir_tab[i].up_ms,
				dir_tab[i].typed, dir_tab[i].want);

		while (n_sent < N_RANDOM) begin
			if ($urandom_range(0, 9) < 8) begin
				// well-formed: a sync followed by queries against it
				sync_up = ($urandom_range(0, 1) == 0) ? $urandom()
					: 32'hFFFF_FFFF - $urandom_range(0, 100000);
				send_word(ucd_pkg::OP_SYNC, pick_epoch(), sync_up, 1'b0, NO_DATE);
				n_q = $urandom_range(1, 6);
				repeat (n_q)
					send_word(ucd_pkg::OP_QUERY, $urandom(), sync_up + pick_elapsed(),
						1'b0, NO_DATE);
				n_sent += n_q + 1;
			end else begin
				// noise: one word of anything
				send_word(1'($urandom_range(0, 1)), $urandom(), $urandom(), 1'b0, NO_DATE);
				n_sent++;
			end
		end
		s_tvalid <= 1'b0;

		// let the monitor log the last word before looking at the queue
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_dates.size() != 0) begin
			$error("%0d results never arrived", pending_dates.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
